@@ src/smap_pkg.sv @@
package smap_pkg;

  // Default size limit of one packet, in bytes.
  localparam int unsigned MaxPacketBytesDef = 1024;

  // STUN header length; attributes start right after it.
  localparam int unsigned HdrBytes = 20;
  localparam logic [17:0] AttrStartReset = 18'(HdrBytes);

  // Header marker byte (first two bytes of a binding success response).
  localparam logic [7:0] HdrMarker = 8'h01;

  // XOR-MAPPED-ADDRESS attribute type and its minimum useful length.
  localparam logic [15:0] XorMappedType = 16'h0020;
  localparam logic [15:0] XorMappedMinLen = 16'd8;

  // Magic cookie; the port is masked with its upper half.
  localparam logic [31:0] MagicCookie = 32'h2112_A442;

  // Byte offsets inside one attribute.
  localparam logic [3:0] OffTypeHi = 4'd0;
  localparam logic [3:0] OffTypeLo = 4'd1;
  localparam logic [3:0] OffLenHi  = 4'd2;
  localparam logic [3:0] OffLenLo  = 4'd3;
  localparam logic [3:0] OffPortHi = 4'd6;
  localparam logic [3:0] OffPortLo = 4'd7;
  localparam logic [3:0] OffAddr3  = 4'd8;
  localparam logic [3:0] OffAddr2  = 4'd9;
  localparam logic [3:0] OffAddr1  = 4'd10;
  localparam logic [3:0] OffAddr0  = 4'd11;

  typedef struct packed {
    logic        found;
    logic [15:0] port;
    logic [31:0] ipv4;
  } result_t;

endpackage

@@ src/stun_mapped_address_parser_unit.sv @@
// Channel | Direction | Handshake             | Word contents
// in      | input     | in_valid_i/in_ready_o   | data_byte_i[7:0], last_byte_i
// out     | output    | out_valid_o/out_ready_i | found_o, mapped_port_o[15:0],
//         |           |                         | mapped_ipv4_o[31:0]
//
// One byte word is taken per cycle while the input side does not stall. A
// byte waits in the input register, and its parse step runs between that
// register and the result register, so a result word is offered from the
// result register once its last byte has moved out of the input register.
// Reset clears the parser and both valid flags; the byte count starts at zero
// and the attribute walk at offset 20.
// Only a last byte can stall: it waits in the input register while the
// result register still holds an untaken word, and the input side stalls
// with it. All other bytes flow at one per cycle regardless of the output.
module stun_mapped_address_parser_unit #(
  parameter int unsigned MAX_PACKET_BYTES = smap_pkg::MaxPacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [15:0] mapped_port_o,
  output logic [31:0] mapped_ipv4_o
);

  logic              st_vld;
  logic [7:0]        st_byte;
  logic              st_last;
  logic              out_free;
  logic              fire;
  smap_pkg::result_t walk_res;
  smap_pkg::result_t out_res;

  // A buffered byte is parsed once it can move on; a last byte also needs
  // room in the result register for the word it produces.
  assign fire = st_vld && (!st_last || out_free);

  smap_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .take_i     (fire),
    .vld_o      (st_vld),
    .byte_o     (st_byte),
    .last_o     (st_last)
  );

  smap_walker #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_walk (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .byte_i(st_byte),
    .last_i(st_last),
    .res_o (walk_res)
  );

  smap_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && st_last),
    .res_i      (walk_res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (out_res)
  );

  assign found_o       = out_res.found;
  assign mapped_port_o = out_res.port;
  assign mapped_ipv4_o = out_res.ipv4;

  // When nothing is found, the port and address fields must read as zero.
  a_zero_when_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> mapped_port_o == 16'h0000 &&
                                mapped_ipv4_o == 32'h0000_0000)
    else $error("nonzero mapped fields without a match");

  // The input side stalls only behind a last byte blocked by a full output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> st_vld && st_last && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

@@ src/smap_in_stage.sv @@
module smap_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;

  // The register can take a new word when it is empty or is being drained.
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

@@ src/smap_walker.sv @@
module smap_walker #(
  parameter int unsigned MAX_PACKET_BYTES = smap_pkg::MaxPacketBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output smap_pkg::result_t res_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  logic [17:0]     nas_q, nas_d;
  logic [15:0]     type_q, type_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     port_q, port_d;
  logic [31:0]     addr_q, addr_d;
  logic            md_q, md_d;

  logic        take;
  logic [17:0] p18;
  logic [17:0] off;
  logic        active;
  logic        near;
  logic [3:0]  o4;
  logic        match_now;
  logic [15:0] len_new;
  logic        match_new;
  logic [16:0] padded;

  assign take      = pos_q < PosW'(MAX_PACKET_BYTES);
  assign p18       = 18'(pos_q);
  assign off       = p18 - nas_q;
  assign active    = take && !md_q && (p18 >= nas_q);
  assign near      = (off[17:4] == 14'd0);
  assign o4        = off[3:0];
  assign match_now = (type_q == smap_pkg::XorMappedType) &&
                     (len_q >= smap_pkg::XorMappedMinLen);
  assign len_new   = {len_q[15:8], byte_i};
  assign match_new = (type_q == smap_pkg::XorMappedType) &&
                     (len_new >= smap_pkg::XorMappedMinLen);
  assign padded    = (17'(len_new) + 17'd3) & ~17'd3;

  always_comb begin
    pos_d  = take ? pos_q + PosW'(1) : pos_q;
    hdr_d  = hdr_q;
    nas_d  = nas_q;
    type_d = type_q;
    len_d  = len_q;
    port_d = port_q;
    addr_d = addr_q;
    md_d   = md_q;

    if (take && pos_q == PosW'(0)) begin
      hdr_d = (byte_i == smap_pkg::HdrMarker);
    end else if (take && pos_q == PosW'(1)) begin
      hdr_d = hdr_q && (byte_i == smap_pkg::HdrMarker);
    end

    if (active && near) begin
      unique case (o4)
        smap_pkg::OffTypeHi: type_d = {byte_i, 8'h00};
        smap_pkg::OffTypeLo: type_d = {type_q[15:8], byte_i};
        smap_pkg::OffLenHi:  len_d  = {byte_i, 8'h00};
        smap_pkg::OffLenLo: begin
          len_d = len_new;
          if (!match_new) begin
            nas_d = nas_q + 18'd4 + 18'(padded);
          end
        end
        smap_pkg::OffPortHi: if (match_now) begin
          port_d = {byte_i ^ smap_pkg::MagicCookie[31:24], 8'h00};
        end
        smap_pkg::OffPortLo: if (match_now) begin
          port_d = {port_q[15:8], byte_i ^ smap_pkg::MagicCookie[23:16]};
        end
        smap_pkg::OffAddr3: if (match_now) begin
          addr_d = {byte_i ^ smap_pkg::MagicCookie[31:24], 24'h000000};
        end
        smap_pkg::OffAddr2: if (match_now) begin
          addr_d[23:16] = byte_i ^ smap_pkg::MagicCookie[23:16];
        end
        smap_pkg::OffAddr1: if (match_now) begin
          addr_d[15:8] = byte_i ^ smap_pkg::MagicCookie[15:8];
        end
        smap_pkg::OffAddr0: if (match_now) begin
          addr_d[7:0] = byte_i ^ smap_pkg::MagicCookie[7:0];
          md_d        = 1'b1;
        end
        default: ;
      endcase
    end

    res_o.found = hdr_d && md_d && (pos_d >= PosW'(smap_pkg::HdrBytes));
    res_o.port  = res_o.found ? port_d : 16'h0000;
    res_o.ipv4  = res_o.found ? addr_d : 32'h0000_0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr_q  <= 1'b0;
      nas_q  <= smap_pkg::AttrStartReset;
      type_q <= '0;
      len_q  <= '0;
      port_q <= '0;
      addr_q <= '0;
      md_q   <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        pos_q  <= '0;
        hdr_q  <= 1'b0;
        nas_q  <= smap_pkg::AttrStartReset;
        type_q <= '0;
        len_q  <= '0;
        port_q <= '0;
        addr_q <= '0;
        md_q   <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        hdr_q  <= hdr_d;
        nas_q  <= nas_d;
        type_q <= type_d;
        len_q  <= len_d;
        port_q <= port_d;
        addr_q <= addr_d;
        md_q   <= md_d;
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_PACKET_BYTES))
    else $error("byte position ran past the packet limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> pos_q == '0 && !md_q && nas_q == smap_pkg::AttrStartReset)
    else $error("parser state not cleared after the last byte");

endmodule

@@ src/smap_out_stage.sv @@
module smap_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  smap_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smap_pkg::result_t res_o
);

  logic              vld_q, vld_d;
  smap_pkg::result_t res_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule
